@@ hdl/mlfq_job_dispatcher_assert.svh @@
// Assertion macros used by the dispatcher checker.
`ifndef MLFQ_JOB_DISPATCHER_ASSERT_SVH
`define MLFQ_JOB_DISPATCHER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define MJD_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("mlfq_job_dispatcher: assertion failed");

// Next-cycle implication, sampled on clock, off during reset.
`define MJD_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("mlfq_job_dispatcher: assertion failed");

`endif

@@ hdl/mjd_pkg.sv @@
// Shared types and constants of the MLFQ job dispatcher.
package mjd_pkg;

   localparam int MAX_JOBS_DEF = 16;

   localparam int JOB_COUNT_W = 5;
   localparam int QUANTUM_W   = 16;
   localparam int PERIOD_W    = 16;
   localparam int TICKS_W     = 16;
   localparam int TIME_W      = 32;
   localparam int JOB_ID_W    = 4;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int REQ_TDATA_W = 56;  // ran_ticks, finished, now, zero fill
   localparam int RSP_TDATA_W = 24;

   localparam logic [JOB_COUNT_W-1:0] JOB_COUNT_RST = 5'd2;
   localparam logic [QUANTUM_W-1:0]   QUANTUM_RST   = 16'd9;
   localparam logic [PERIOD_W-1:0]    PERIOD_RST    = 16'd10;
   localparam logic                   EXT_MODE_RST  = 1'b1;

   localparam logic OP_START  = 1'b0;
   localparam logic OP_REPORT = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_JOB_COUNT    = 2'd0,
      CSR_QUANTUM      = 2'd1,
      CSR_BOOST_PERIOD = 2'd2,
      CSR_EXT_MODE     = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      LVL_TOP = 2'd0,
      LVL_MID = 2'd1,
      LVL_BOT = 2'd2
   } level_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_BOOST,
      ST_LEVEL,
      ST_SCAN,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic capture;     // item taken, allotment of last job read
      logic update;      // apply start or report
      logic boost;       // periodic boost check
      logic pick_level;  // choose level, load scan position
      logic scan;        // test one job entry
      logic emit;        // load result register, commit dispatch
   } cmd_type;

   typedef struct packed {
      logic found;       // some active job exists at a level
      logic hit;         // scanned entry matches
      logic out_free;    // result register can take a result
   } stat_type;

endpackage

@@ hdl/mjd_ctrl.sv @@
// Controller state machine of the MLFQ job dispatcher.
module mjd_ctrl
   import mjd_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     req_tvalid,
   output logic     req_tready,
   input  stat_type stat,
   output cmd_type  cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: state_in = ST_BOOST;
         ST_BOOST:  state_in = ST_LEVEL;
         ST_LEVEL: begin
            state_in = stat.found ? ST_SCAN : ST_EMIT;
         end
         ST_SCAN: begin
            if (stat.hit) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_UPDATE: cmd.update     = 1'b1;
         ST_BOOST:  cmd.boost      = 1'b1;
         ST_LEVEL:  cmd.pick_level = 1'b1;
         ST_SCAN:   cmd.scan       = 1'b1;
         ST_EMIT:   cmd.emit       = stat.out_free;
         default:   cmd            = '0;
      endcase
   end

endmodule

@@ hdl/mjd_datapath.sv @@
// Datapath of the MLFQ job dispatcher: job table, allotment memory, result register.
module mjd_datapath
   import mjd_pkg::*;
#(
   parameter int MAX_JOBS = MAX_JOBS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cmd_type                cmd,
   output stat_type               stat,
   input  logic                   req_tuser,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W  = $clog2(MAX_JOBS);
   localparam int CNT_NW = $clog2(MAX_JOBS + 1);
   localparam int CNT_W  = (CNT_NW > JOB_COUNT_W) ? CNT_NW : JOB_COUNT_W;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_JOBS - 1);
   localparam logic [CNT_W-1:0] MAX_CNT  = CNT_W'(MAX_JOBS);

   // configuration
   logic [JOB_COUNT_W-1:0] job_count_ff;
   logic [QUANTUM_W-1:0]   quantum_ff;
   logic [PERIOD_W-1:0]    period_ff;
   logic                   ext_ff;

   // captured item
   logic                   op_ff;
   logic [TICKS_W-1:0]     ran_ff;
   logic                   fin_ff;
   logic [TIME_W-1:0]      now_ff;

   // job table
   logic [MAX_JOBS-1:0]    active_ff, active_in;
   logic [MAX_JOBS-1:0]    started_ff, started_in;
   logic [MAX_JOBS-1:0]    alloc_vld_ff, alloc_vld_in;
   level_type              level_ff [MAX_JOBS];
   level_type              level_in [MAX_JOBS];

   // allotment memory, entries not written since start read as start quantum
   logic [QUANTUM_W-1:0]   alloc_mem [MAX_JOBS];
   logic [QUANTUM_W-1:0]   rd_q_ff;
   logic                   rd_vld_ff;
   logic                   rd_en;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [QUANTUM_W-1:0]   wr_data;
   logic [QUANTUM_W-1:0]   alloc_cur;

   // scheduler state
   logic [QUANTUM_W-1:0]   start_q_ff, start_q_in;
   level_type              level_now_ff, level_now_in;
   logic [IDX_W-1:0]       scan_ptr_ff, scan_ptr_in;
   logic [IDX_W-1:0]       last_job_ff, last_job_in;
   logic [TIME_W-1:0]      next_boost_ff, next_boost_in;
   logic                   pending_ff, pending_in;
   logic                   boosted_ff, boosted_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       scan_k_ff, scan_k_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff;

   // derived
   logic [CNT_W-1:0]       n_jobs;
   logic [MAX_JOBS-1:0]    at_top, at_mid, at_bot;
   logic [2:0]             has;
   logic                   any_active;
   level_type              pick_lvl;
   logic                   hit;
   logic [QUANTUM_W-1:0]   lim;
   logic [IDX_W-1:0]       j_next;
   logic [IDX_W-1:0]       k_next;
   logic                   do_boost;
   logic [IDX_W+JOB_ID_W-1:0] id_ext;
   logic [RSP_TDATA_W-1:0] rsp_data_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         job_count_ff <= JOB_COUNT_RST;
         quantum_ff   <= QUANTUM_RST;
         period_ff    <= PERIOD_RST;
         ext_ff       <= EXT_MODE_RST;
      end else if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_JOB_COUNT:    job_count_ff <= csr_data[JOB_COUNT_W-1:0];
            CSR_QUANTUM:      quantum_ff   <= csr_data[QUANTUM_W-1:0];
            CSR_BOOST_PERIOD: period_ff    <= csr_data[PERIOD_W-1:0];
            CSR_EXT_MODE:     ext_ff       <= csr_data[0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff  <= req_tuser;
         ran_ff <= req_tdata[15:0];
         fin_ff <= req_tdata[16];
         now_ff <= req_tdata[48:17];
      end
   end

   // allotment memory
   assign rd_en   = cmd.capture || (cmd.scan && hit);
   assign rd_addr = cmd.capture ? last_job_ff : scan_k_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         alloc_mem[last_job_ff] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff   <= alloc_mem[rd_addr];
         rd_vld_ff <= alloc_vld_ff[rd_addr];
      end
   end

   assign alloc_cur = rd_vld_ff ? rd_q_ff : start_q_ff;

   // level occupancy
   always_comb begin
      for (int i = 0; i < MAX_JOBS; i++) begin
         at_top[i] = active_ff[i] && (level_ff[i] == LVL_TOP);
         at_mid[i] = active_ff[i] && (level_ff[i] == LVL_MID);
         at_bot[i] = active_ff[i] && (level_ff[i] == LVL_BOT);
      end
   end

   assign has        = {|at_bot, |at_mid, |at_top};
   assign any_active = |active_ff;

   // first occupied level at or below the current one, else from the top
   always_comb begin
      pick_lvl = LVL_TOP;
      unique case (level_now_ff)
         LVL_MID: begin
            if (has[1])      pick_lvl = LVL_MID;
            else if (has[2]) pick_lvl = LVL_BOT;
            else             pick_lvl = LVL_TOP;
         end
         LVL_BOT: begin
            if (has[2])      pick_lvl = LVL_BOT;
            else if (has[0]) pick_lvl = LVL_TOP;
            else             pick_lvl = LVL_MID;
         end
         default: begin
            if (has[0])      pick_lvl = LVL_TOP;
            else if (has[1]) pick_lvl = LVL_MID;
            else             pick_lvl = LVL_BOT;
         end
      endcase
   end

   assign hit      = active_ff[scan_k_ff] && (level_ff[scan_k_ff] == level_now_ff);
   assign lim      = ext_ff ? alloc_cur : quantum_ff;
   assign j_next   = (last_job_ff == LAST_IDX) ? '0 : last_job_ff + 1'b1;
   assign k_next   = (scan_k_ff == LAST_IDX) ? '0 : scan_k_ff + 1'b1;
   assign do_boost = ext_ff && any_active && (now_ff >= next_boost_ff);
   assign id_ext   = {{JOB_ID_W{1'b0}}, scan_k_ff};

   assign n_jobs = (job_count_ff == '0) ? CNT_W'(1) :
                   ((CNT_W'(job_count_ff) > MAX_CNT) ? MAX_CNT : CNT_W'(job_count_ff));

   assign rsp_data_in = found_ff ?
      {boosted_ff, !any_active, !started_ff[scan_k_ff], lim,
       id_ext[JOB_ID_W-1:0], 1'b1} :
      {boosted_ff, !any_active, 1'b0, {QUANTUM_W{1'b0}}, {JOB_ID_W{1'b0}}, 1'b0};

   always_comb begin
      active_in     = active_ff;
      started_in    = started_ff;
      alloc_vld_in  = alloc_vld_ff;
      level_in      = level_ff;
      start_q_in    = start_q_ff;
      level_now_in  = level_now_ff;
      scan_ptr_in   = scan_ptr_ff;
      last_job_in   = last_job_ff;
      next_boost_in = next_boost_ff;
      pending_in    = pending_ff;
      boosted_in    = boosted_ff;
      found_in      = found_ff;
      scan_k_in     = scan_k_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      wr_en         = 1'b0;
      wr_data       = quantum_ff;

      if (cmd.update) begin
         if (op_ff == OP_START) begin
            for (int i = 0; i < MAX_JOBS; i++) begin
               active_in[i] = (CNT_W'(i) < n_jobs);
               level_in[i]  = LVL_TOP;
            end
            started_in    = '0;
            alloc_vld_in  = '0;
            start_q_in    = quantum_ff;
            level_now_in  = LVL_TOP;
            scan_ptr_in   = '0;
            last_job_in   = '0;
            next_boost_in = {{(TIME_W-PERIOD_W){1'b0}}, period_ff};
            pending_in    = 1'b0;
         end else if (pending_ff) begin
            if (fin_ff) begin
               active_in[last_job_ff] = 1'b0;
            end else if (ran_ff >= lim) begin
               level_in[last_job_ff] =
                  (level_ff[last_job_ff] == LVL_TOP) ? LVL_MID : LVL_BOT;
               wr_en   = 1'b1;
               wr_data = quantum_ff;
               alloc_vld_in[last_job_ff] = 1'b1;
            end else if (ext_ff) begin
               wr_en   = 1'b1;
               wr_data = lim - ran_ff;
               alloc_vld_in[last_job_ff] = 1'b1;
            end
            scan_ptr_in = j_next;
            pending_in  = 1'b0;
         end
      end

      if (cmd.boost) begin
         boosted_in = do_boost;
         if (do_boost) begin
            next_boost_in = next_boost_ff + {{(TIME_W-PERIOD_W){1'b0}}, period_ff};
            for (int i = 0; i < MAX_JOBS; i++) begin
               if (active_ff[i]) begin
                  level_in[i] = LVL_TOP;
               end
            end
            level_now_in = LVL_TOP;
         end
      end

      if (cmd.pick_level) begin
         found_in  = |has;
         scan_k_in = scan_ptr_ff;
         if (|has) begin
            level_now_in = pick_lvl;
         end
      end

      if (cmd.scan && !hit) begin
         scan_k_in = k_next;
      end

      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            started_in[scan_k_ff] = 1'b1;
            scan_ptr_in = scan_k_ff;
            last_job_in = scan_k_ff;
            pending_in  = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff     <= '0;
         started_ff    <= '0;
         alloc_vld_ff  <= '0;
         for (int i = 0; i < MAX_JOBS; i++) begin
            level_ff[i] <= LVL_TOP;
         end
         start_q_ff    <= QUANTUM_RST;
         level_now_ff  <= LVL_TOP;
         scan_ptr_ff   <= '0;
         last_job_ff   <= '0;
         next_boost_ff <= {{(TIME_W-PERIOD_W){1'b0}}, PERIOD_RST};
         pending_ff    <= 1'b0;
         boosted_ff    <= 1'b0;
         found_ff      <= 1'b0;
         scan_k_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         active_ff     <= active_in;
         started_ff    <= started_in;
         alloc_vld_ff  <= alloc_vld_in;
         level_ff      <= level_in;
         start_q_ff    <= start_q_in;
         level_now_ff  <= level_now_in;
         scan_ptr_ff   <= scan_ptr_in;
         last_job_ff   <= last_job_in;
         next_boost_ff <= next_boost_in;
         pending_ff    <= pending_in;
         boosted_ff    <= boosted_in;
         found_ff      <= found_in;
         scan_k_ff     <= scan_k_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign stat.found    = |has;
   assign stat.hit      = hit;
   assign stat.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ hdl/mlfq_job_dispatcher.sv @@
// Top level of the three-level feedback queue job dispatcher.
//
//  port group   dir   handshake              payload
//  req_*        in    req_tvalid/req_tready  tuser: op; tdata: ran_ticks, finished, now
//  rsp_*        out   rsp_tvalid/rsp_tready  tdata: dispatch, id, budget, first, done, boost
//  csr_*        in    csr_valid/csr_ready    csr_index, csr_data
//
//  One item at a time: an accepted item passes the UPDATE, BOOST and LEVEL states,
//  then SCAN, which visits one job entry per cycle in round-robin order (1..MAX_JOBS
//  entries, skipped when no job is active), then EMIT, which loads the result register
//  and raises rsp_tvalid; the next item can be taken once rsp_tvalid is up.
//  Synchronous active-high reset; no clearing pass, the block is ready right after.
//  A finished result waits in the output register; the next item can be accepted
//  meanwhile, and a stalled rsp side holds the block only at its next result.
module mlfq_job_dispatcher
   import mjd_pkg::*;
#(
   parameter int MAX_JOBS = MAX_JOBS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic                   req_tuser,  // [0] op
   input  logic [REQ_TDATA_W-1:0] req_tdata,  // [15:0] ran_ticks, [16] finished, [48:17] now
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,  // [0] dispatch_valid, [4:1] job_id,
                                              // [20:5] run_budget, [21] first_run,
                                              // [22] all_done, [23] boost_applied
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   mjd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   mjd_datapath #(
      .MAX_JOBS (MAX_JOBS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

endmodule

@@ hdl/mjd_checker.sv @@
// Port-level checker for the MLFQ job dispatcher, bound to the top level.
`include "mlfq_job_dispatcher_assert.svh"

module mjd_checker
   import mjd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // no dispatch carries zero id, budget and first flag
   `MJD_ASSERT_IMP(a_idle_fields_zero, rsp_tvalid && !rsp_tdata[0], rsp_tdata[21:1] == 21'd0)

   // a dispatched job is active, so not all done
   `MJD_ASSERT_IMP(a_dispatch_not_done, rsp_tvalid && rsp_tdata[0], !rsp_tdata[22])

   // a boost needs an active job, and boosting never retires one
   `MJD_ASSERT_IMP(a_boost_not_done, rsp_tvalid && rsp_tdata[23], !rsp_tdata[22])

   // one item at a time: busy right after an item is taken
   `MJD_ASSERT_NXT(a_busy_after_accept, req_tvalid && req_tready, !req_tready)

   `MJD_ASSERT_NXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata))

endmodule

bind mlfq_job_dispatcher mjd_checker u_mjd_checker (.*);

@@ tb/job_dispatch_tb_pkg.sv @@
// Dispatcher behavior model and result tracker used by tb_top.
`timescale 1ns / 1ps
package job_dispatch_tb_pkg;
   import mjd_pkg::*;

   localparam int JOBS = MAX_JOBS_DEF;

   typedef struct {
      logic        valid;
      logic [3:0]  id;
      logic [15:0] budget;
      logic        first;
      logic        done;
      logic        boost;
   } pick_type;

   class job_dispatch_model_type;
      // register copies
      logic [4:0]  cfg_jobs;
      logic [15:0] cfg_quantum;
      logic [15:0] cfg_period;
      logic        cfg_ext;

      // job table and scheduler state
      level_type   lvl [JOBS];
      bit          active [JOBS];
      bit          started [JOBS];
      logic [15:0] allot [JOBS];
      level_type   cur_lvl;
      logic [3:0]  scan_ptr;
      logic [3:0]  last_id;
      logic [31:0] next_boost;
      bit          awaiting_report;
      logic [15:0] last_budget;

      pick_type    pending_picks[$];

      int errors, picks_seen, dispatches, demotions, boosts, idle_results, sessions;

      function new();
         cfg_jobs    = JOB_COUNT_RST;
         cfg_quantum = QUANTUM_RST;
         cfg_period  = PERIOD_RST;
         cfg_ext     = EXT_MODE_RST;
         for (int i = 0; i < JOBS; i++) begin
            lvl[i]     = LVL_TOP;
            active[i]  = 0;
            started[i] = 0;
            allot[i]   = QUANTUM_RST;
         end
         cur_lvl         = LVL_TOP;
         scan_ptr        = '0;
         last_id         = '0;
         next_boost      = {16'b0, PERIOD_RST};
         awaiting_report = 0;
         last_budget     = '0;
      endfunction

      function void set_reg(csr_idx_type idx, logic [15:0] val);
         case (idx)
            CSR_JOB_COUNT:    cfg_jobs    = val[4:0];
            CSR_QUANTUM:      cfg_quantum = val;
            CSR_BOOST_PERIOD: cfg_period  = val;
            CSR_EXT_MODE:     cfg_ext     = val[0];
            default: ;
         endcase
      endfunction

      function bit any_active();
         for (int i = 0; i < JOBS; i++)
            if (active[i]) return 1;
         return 0;
      endfunction

      function bit level_has(level_type l);
         for (int i = 0; i < JOBS; i++)
            if (active[i] && lvl[i] == l) return 1;
         return 0;
      endfunction

      function int outstanding();
         return pending_picks.size();
      endfunction

      // One accepted item in, one expected pick out.
      function void take_item(logic op, logic [15:0] ran, logic fin, logic [31:0] now);
         pick_type    exp;
         int          n;
         int          l;
         bit          found;
         logic [3:0]  j;
         logic [3:0]  k;
         logic [15:0] lim;
         exp = '{default: '0};
         found = 0;
         if (op == OP_START) begin
            n = cfg_jobs;
            if (n < 1) n = 1;
            if (n > JOBS) n = JOBS;
            for (int i = 0; i < JOBS; i++) begin
               active[i]  = (i < n);
               lvl[i]     = LVL_TOP;
               started[i] = 0;
               allot[i]   = cfg_quantum;
            end
            cur_lvl         = LVL_TOP;
            scan_ptr        = '0;
            last_id         = '0;
            next_boost      = {16'b0, cfg_period};
            awaiting_report = 0;
            sessions++;
         end else if (awaiting_report) begin
            j = last_id;
            if (fin) begin
               active[j] = 0;
            end else begin
               lim = cfg_ext ? allot[j] : cfg_quantum;
               if (ran >= lim) begin
                  lvl[j]   = (lvl[j] == LVL_TOP) ? LVL_MID : LVL_BOT;
                  allot[j] = cfg_quantum;
                  demotions++;
               end else if (cfg_ext) begin
                  allot[j] = lim - ran;
               end
            end
            scan_ptr        = j + 4'd1;
            awaiting_report = 0;
         end

         if (cfg_ext && any_active() && now >= next_boost) begin
            next_boost = next_boost + {16'b0, cfg_period};
            for (int i = 0; i < JOBS; i++)
               if (active[i]) lvl[i] = LVL_TOP;
            cur_lvl   = LVL_TOP;
            exp.boost = 1;
            boosts++;
         end

         // search down from the current level, then wrap to the top
         for (l = int'(cur_lvl); l <= int'(LVL_BOT) && !found; l++)
            if (level_has(level_type'(l))) begin
               cur_lvl = level_type'(l);
               found   = 1;
            end
         for (l = int'(LVL_TOP); l <= int'(LVL_BOT) && !found; l++)
            if (level_has(level_type'(l))) begin
               cur_lvl = level_type'(l);
               found   = 1;
            end

         if (found) begin
            for (int i = 0; i < JOBS; i++) begin
               k = scan_ptr + 4'(i);
               if (active[k] && lvl[k] == cur_lvl) begin
                  exp.valid       = 1;
                  exp.id          = k;
                  exp.budget      = cfg_ext ? allot[k] : cfg_quantum;
                  exp.first       = !started[k];
                  started[k]      = 1;
                  scan_ptr        = k;
                  last_id         = k;
                  awaiting_report = 1;
                  last_budget     = exp.budget;
                  dispatches++;
                  break;
               end
            end
         end
         exp.done = !any_active();
         if (exp.done) idle_results++;
         pending_picks.push_back(exp);
      endfunction

      function void cmp(string what, int unsigned e, int unsigned a);
         if (e != a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, e, a);
         end
      endfunction

      function void match_pick(logic [23:0] d);
         pick_type exp;
         if (pending_picks.size() == 0) begin
            errors++;
            $display("%0t: result %06h arrived with no item waiting for it", $time, d);
            return;
         end
         exp = pending_picks.pop_front();
         picks_seen++;
         cmp("dispatch_valid", exp.valid, d[0]);
         cmp("job_id", exp.id, d[4:1]);
         cmp("run_budget", exp.budget, d[20:5]);
         cmp("first_run", exp.first, d[21]);
         cmp("all_done", exp.done, d[22]);
         cmp("boost_applied", exp.boost, d[23]);
      endfunction
   endclass

endpackage

@@ tb/tb_top.sv @@
// Top-level testbench of the MLFQ job dispatcher: stimulus, stalls and result checks.
`timescale 1ns / 1ps
module tb_top;
   import mjd_pkg::*;
   import job_dispatch_tb_pkg::*;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic                   req_tuser = 1'b0;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   job_dispatch_model_type model = new();

   int          items_sent = 0;
   int          reg_writes = 0;
   bit          no_idle = 0;
   bit          squeezed = 0;
   logic [31:0] now_ticks = '0;

   always #1 clock = ~clock;

   mlfq_job_dispatcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   task automatic send_item(input logic op, input logic [15:0] ran, input logic fin,
                            input logic [31:0] now);
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {7'b0, now, fin, ran};
      do @(posedge clock); while (!req_tready);
      model.take_item(op, ran, fin, now);
      items_sent++;
   endtask

   task automatic idle_gap(input int n);
      if (n > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (n - 1) @(negedge clock);
      end
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [15:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      model.set_reg(idx, val);
      reg_writes++;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // wait for every result, then let the scan run dry before touching registers
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (model.outstanding() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (no_idle || r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   // ticks used, placed around the granted budget
   function automatic logic [15:0] pick_ran(input logic [15:0] b);
      int r;
      int v;
      r = $urandom_range(0, 9);
      case (r)
         0: v = 0;
         5: v = int'(b) - 1;
         6, 7: v = int'(b);
         8: v = int'(b) + $urandom_range(1, 12);
         9: v = $urandom_range(0, 65535);
         default: v = (b > 0) ? $urandom_range(0, int'(b) - 1) : 0;
      endcase
      if (v < 0) v = 0;
      if (v > 65535) v = 65535;
      return v[15:0];
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) model.match_pick(rsp_tdata);
   end

   // result side back-pressure
   initial begin
      int run_left;
      int r;
      run_left = 0;
      forever begin
         @(negedge clock);
         if (!squeezed && items_sent >= 400) begin
            // long hold-off so the input side backs up
            squeezed = 1;
            rsp_tready <= 1'b0;
            repeat (399) @(negedge clock);
            run_left = 0;
         end else begin
            if (run_left == 0) begin
               r = $urandom_range(0, 99);
               if (r < 8) begin
                  rsp_tready <= 1'b1;
                  run_left = $urandom_range(100, 300);
               end else if (r < 70) begin
                  rsp_tready <= 1'b1;
                  run_left = $urandom_range(1, 30);
               end else if (r < 93) begin
                  rsp_tready <= 1'b0;
                  run_left = $urandom_range(1, 3);
               end else if (r < 98) begin
                  rsp_tready <= 1'b0;
                  run_left = $urandom_range(4, 12);
               end else begin
                  rsp_tready <= 1'b0;
                  run_left = $urandom_range(20, 60);
               end
            end
            run_left--;
         end
      end
   end

   initial begin
      #1_500_000;
      $display("%0t: run did not complete in time", $time);
      $display("end of test: mismatches");
      $finish;
   end

   initial begin
      int r;
      logic [15:0] ran;
      logic        fin;
      logic [15:0] qv;
      logic [15:0] pv;
      logic [4:0]  jv;

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // nothing started yet: reports are ignored, no job is live
      send_item(OP_REPORT, 16'hFFFF, 1'b1, 32'hFFFF_FFFF);
      send_item(OP_REPORT, 16'h0000, 1'b0, 32'h0);
      // reset settings: two jobs, quantum 9, boost every 10
      send_item(OP_START, 16'h0, 1'b0, 32'd0);
      send_item(OP_REPORT, 16'd3, 1'b0, 32'd3);       // early yield, allotment shrinks
      send_item(OP_REPORT, 16'd9, 1'b0, 32'd12);      // full use plus boost
      send_item(OP_REPORT, 16'hFFFF, 1'b0, 32'd13);
      send_item(OP_REPORT, 16'd0, 1'b1, 32'd14);
      send_item(OP_REPORT, 16'd5, 1'b1, 32'd40);      // last job done
      send_item(OP_REPORT, 16'd1, 1'b0, 32'd41);      // nothing pending
      settle();

      // plain mode, count 0 taken as one job, smallest quantum
      write_reg(CSR_EXT_MODE, 16'd0);
      write_reg(CSR_JOB_COUNT, 16'd0);
      write_reg(CSR_QUANTUM, 16'd1);
      send_item(OP_START, 16'h0, 1'b0, 32'd0);
      send_item(OP_REPORT, 16'd0, 1'b0, 32'd100);
      send_item(OP_REPORT, 16'd1, 1'b0, 32'd200);     // top to middle
      send_item(OP_REPORT, 16'd1, 1'b0, 32'd300);     // middle to bottom
      send_item(OP_REPORT, 16'd1, 1'b0, 32'hFFFF_FFFF); // bottom stays
      settle();

      // count above the table size, largest quantum, boost every tick
      write_reg(CSR_JOB_COUNT, 16'd31);
      write_reg(CSR_QUANTUM, 16'hFFFF);
      write_reg(CSR_BOOST_PERIOD, 16'd1);
      write_reg(CSR_EXT_MODE, 16'd1);
      send_item(OP_START, 16'hFFFF, 1'b1, 32'd0);
      send_item(OP_REPORT, 16'hFFFE, 1'b0, 32'h8000_0000);
      send_item(OP_REPORT, 16'hFFFF, 1'b0, 32'h7FFF_FFFF);
      send_item(OP_REPORT, 16'hAAAA, 1'b1, 32'h5555_5555);
      send_item(OP_REPORT, 16'h5555, 1'b0, 32'hAAAA_AAAA);
      settle();
      write_reg(CSR_JOB_COUNT, 16'd17);
      write_reg(CSR_BOOST_PERIOD, 16'hFFFF);
      send_item(OP_START, 16'h0, 1'b0, 32'd5);
      send_item(OP_REPORT, 16'hFFFF, 1'b0, 32'h0001_0000);

      for (int p = 0; p < 8; p++) begin
         settle();
         case (p % 4)
            0: jv = 5'd1;
            1: jv = 5'd16;
            2: jv = 5'($urandom_range(0, 31));
            default: jv = 5'($urandom_range(2, 8));
         endcase
         if (p == 2) qv = 16'hFFFF;
         else if (p == 5) qv = 16'd1;
         else if (p == 7) qv = 16'($urandom_range(1, 65535));
         else qv = 16'($urandom_range(2, 40));
         if (p == 3) pv = 16'd1;
         else if (p == 6) pv = 16'hFFFF;
         else pv = 16'($urandom_range(5, 300));
         write_reg(CSR_JOB_COUNT, {11'b0, jv});
         write_reg(CSR_QUANTUM, qv);
         write_reg(CSR_BOOST_PERIOD, pv);
         write_reg(CSR_EXT_MODE, {15'b0, (p % 3 != 1)});
         no_idle = (p == 4);

         now_ticks = $urandom_range(0, 3);
         send_item(OP_START, 16'($urandom), 1'($urandom_range(0, 1)), now_ticks);
         for (int i = 0; i < 150; i++) begin
            idle_gap(pick_gap());
            r = $urandom_range(0, 99);
            if (r < 4) begin
               now_ticks = (r < 2) ? $urandom : $urandom_range(0, 3);
               send_item(OP_START, 16'($urandom), 1'($urandom_range(0, 1)), now_ticks);
            end else if (r < 12) begin
               send_item(OP_REPORT, 16'($urandom), 1'($urandom_range(0, 1)),
                         (r < 8) ? $urandom : now_ticks);
            end else if (!model.awaiting_report) begin
               // everything finished: begin a fresh session
               now_ticks = $urandom_range(0, 3);
               send_item(OP_START, 16'($urandom), 1'($urandom_range(0, 1)), now_ticks);
            end else begin
               ran = pick_ran(model.last_budget);
               fin = ($urandom_range(0, 99) < 7);
               if ($urandom_range(0, 99) < 3) now_ticks = $urandom;
               else now_ticks = now_ticks + ran + $urandom_range(0, 3);
               send_item(OP_REPORT, ran, fin, now_ticks);
            end
         end
      end

      @(negedge clock);
      req_tvalid <= 1'b0;
      while (model.outstanding() != 0) @(posedge clock);
      repeat (40) @(posedge clock);

      if (model.outstanding() != 0) begin
         model.errors++;
         $display("%0t: %0d results never arrived", $time, model.outstanding());
      end
      $display("Covered %0d items over %0d sessions and %0d register writes.",
               items_sent, model.sessions, reg_writes);
      $display("Checked %0d results: %0d dispatches, %0d demotions, %0d boosts, %0d idle.",
               model.picks_seen, model.dispatches, model.demotions, model.boosts,
               model.idle_results);
      if (model.errors == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
